// File: hw/rtl/stns_pkg.sv
// ----------------------------------------------------------------------------
// stns_pkg: shared types and constants for the sorted table neighbor search
// Table geometry, request kinds, response status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stns_pkg;

   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;

   // response payload: status, below_found, below_value, above_found, above_value
   localparam int RSP_W       = STAT_W + 1 + DATA_W + 1 + DATA_W;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;

   typedef struct packed {
      logic load;      // latch request, arm both searches
      logic exec;      // clear / append update
      logic search;    // one search cycle
      logic load_out;  // move result into the response register
   } stns_cmd_type;

   typedef struct packed {
      logic is_query;
      logic search_done;
      logic out_free;
   } stns_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/stns_ram.sv
// ----------------------------------------------------------------------------
// stns_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/stns_ctrl.sv
// ----------------------------------------------------------------------------
// stns_ctrl: request sequencer
// Walks each request through latch, update or search, and response load.
// ----------------------------------------------------------------------------
`default_nettype none

module stns_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_fire,
   output logic                        req_ready,
   input  wire stns_pkg::stns_stat_type stat,
   output stns_pkg::stns_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_query) begin
               state_in = S_SEARCH;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_RESP;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.search_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/stns_dp.sv
// ----------------------------------------------------------------------------
// stns_dp: table storage, search unit and response register
// Two lower-bound searches (strictly-less and less-or-equal) share the table
// read port on alternate cycles, so each probe's compare overlaps the other
// search's read.
// ----------------------------------------------------------------------------
`default_nettype none

module stns_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [stns_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [stns_pkg::DATA_W-1:0]    req_value,
   input  wire stns_pkg::stns_cmd_type         cmd,
   output stns_pkg::stns_stat_type             stat,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [stns_pkg::RSP_TDATA_W-1:0]    rsp_data
);

   localparam int CW = stns_pkg::CNT_W;
   localparam int DW = stns_pkg::DATA_W;

   logic [stns_pkg::KIND_W-1:0] kind_ff;
   logic [DW-1:0]               key_ff;
   logic [CW-1:0]               count_ff;
   logic [DW-1:0]               last_ff;
   logic [CW-1:0]               lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff;
   logic [CW-1:0]               mid_ff;
   logic                        phase_ff, issued_ff, issued_side_ff;
   logic [DW-1:0]               below_ff, above_ff;
   logic [stns_pkg::STAT_W-1:0] st_ff;
   logic                        rsp_valid_ff;
   logic [stns_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic [CW-1:0]  lo_s, hi_s;
   logic [CW:0]    mid_sum;
   logic [CW-1:0]  mid_w, mid_next;
   logic           probe;
   logic [DW-1:0]  rd_data;
   logic           is_full, is_order, wr_en;
   logic           below_found, above_found;
   logic [stns_pkg::STAT_W-1:0] exec_st;

   // probe address for the side whose turn it is
   assign lo_s     = phase_ff ? lo_b_ff : lo_a_ff;
   assign hi_s     = phase_ff ? hi_b_ff : hi_a_ff;
   assign probe    = cmd.search && (lo_s < hi_s);
   assign mid_sum  = {1'b0, lo_s} + {1'b0, hi_s};
   assign mid_w    = mid_sum[CW:1];
   assign mid_next = mid_ff + CW'(1);

   assign is_full  = (count_ff >= CW'(stns_pkg::DEPTH));
   assign is_order = (count_ff != '0) && (key_ff < last_ff);
   assign wr_en    = cmd.exec && (kind_ff == stns_pkg::KIND_APPEND) && !is_full && !is_order;

   always_comb begin
      exec_st = stns_pkg::ST_OK;
      if (kind_ff == stns_pkg::KIND_APPEND) begin
         if (is_full) begin
            exec_st = stns_pkg::ST_FULL;
         end else if (is_order) begin
            exec_st = stns_pkg::ST_ORDER;
         end
      end
   end

   stns_ram #(
      .WIDTH (DW),
      .DEPTH (stns_pkg::DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[stns_pkg::ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (mid_w[stns_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         key_ff   <= req_value;
         lo_a_ff  <= '0;
         hi_a_ff  <= count_ff;
         lo_b_ff  <= '0;
         hi_b_ff  <= count_ff;
         phase_ff <= 1'b0;
         below_ff <= '0;
         above_ff <= '0;
         st_ff    <= stns_pkg::ST_OK;
      end
      if (cmd.exec) begin
         st_ff <= exec_st;
      end
      if (wr_en) begin
         last_ff <= key_ff;
      end
      if (cmd.search) begin
         phase_ff       <= ~phase_ff;
         mid_ff         <= mid_w;
         issued_side_ff <= phase_ff;
         // data for the previous probe is back: narrow that side's range
         if (issued_ff) begin
            if (!issued_side_ff) begin
               if (rd_data < key_ff) begin
                  lo_a_ff  <= mid_next;
                  below_ff <= rd_data;
               end else begin
                  hi_a_ff <= mid_ff;
               end
            end else begin
               if (rd_data <= key_ff) begin
                  lo_b_ff <= mid_next;
               end else begin
                  hi_b_ff  <= mid_ff;
                  above_ff <= rd_data;
               end
            end
         end
      end
   end

   assign below_found = (kind_ff == stns_pkg::KIND_QUERY) && (lo_a_ff != '0);
   assign above_found = (kind_ff == stns_pkg::KIND_QUERY) && (lo_b_ff != count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {{(stns_pkg::RSP_TDATA_W - stns_pkg::RSP_W){1'b0}},
                         above_ff, above_found, below_ff, below_found, st_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec && (kind_ff == stns_pkg::KIND_CLEAR)) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.load) begin
            issued_ff <= 1'b0;
         end else if (cmd.search) begin
            issued_ff <= probe;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.is_query    = (kind_ff == stns_pkg::KIND_QUERY);
   assign stat.search_done = !issued_ff && (lo_a_ff >= hi_a_ff) && (lo_b_ff >= hi_b_ff);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_table_neighbor_search.sv
// ----------------------------------------------------------------------------
// sorted_table_neighbor_search: sorted table with predecessor/successor lookup
// Append, clear and neighbor-query requests against a sorted table.
// ----------------------------------------------------------------------------
// Request channel (req_): tuser carries the kind (clear, append, query), tdata
// the 32-bit value. Response channel (rsp_): one response per request, with
// status and, for a query, the greatest stored value below the key and the
// least stored value above it, each with a found flag.
// Appends must be non-decreasing; a full table or an out-of-order append is
// dropped and flagged in the status.
// Requests are handled one at a time. A clear or append goes from accept
// through the update state to the response-load state. A query runs two
// binary searches over the n stored entries; they share the table's single
// read port on alternate cycles, each probe needing one read plus one compare.
// The response sits in an output register; while the receiver stalls, one more
// request is accepted and waits in the controller, then the input stalls.
// Reset empties the table and drops any pending response; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_neighbor_search (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [stns_pkg::DATA_W-1:0]         req_tdata,  // [31:0] value
   input  wire logic [stns_pkg::KIND_W-1:0]         req_tuser,  // [1:0] kind
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [2] below_found, [34:3] below_value, [35] above_found,
   // [67:36] above_value, [71:68] zero
   output logic [stns_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   stns_pkg::stns_cmd_type  cmd;
   stns_pkg::stns_stat_type stat;
   logic                    req_fire;

   assign req_fire = req_tvalid && req_tready;

   stns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stns_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_kind  (req_tuser),
      .req_value (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

`ifndef SYNTH
   // one request in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == stns_pkg::ST_OK ||
                      rsp_tdata[1:0] == stns_pkg::ST_FULL ||
                      rsp_tdata[1:0] == stns_pkg::ST_ORDER))
      else $error("bad response status");

   // neighbors bracket the key, so below must be strictly less than above
   a_neighbor_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] && rsp_tdata[35] |-> rsp_tdata[34:3] < rsp_tdata[67:36])
      else $error("below neighbor not less than above neighbor");

   a_drop_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != stns_pkg::ST_OK) |-> !rsp_tdata[2] && !rsp_tdata[35])
      else $error("dropped append reports neighbors");
`endif

endmodule

`default_nettype wire
